@@ rtl/plc_pkg.sv @@
// Package for the positional list store: beat types, operation and status
// codes, and the control word broadcast along the row of entry cells.
// No dependencies.
package plc_pkg;

  // Fixed field widths of the request and response beats.
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_APPEND   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PREPEND  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_HEAD = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_TAIL = 3'd5;
  localparam logic [FUNC_W-1:0] FN_DEL_AT   = 3'd6;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // Value returned by a read at a bad index.
  localparam logic signed [VALUE_W-1:0] READ_BAD = -32'sd1;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
  } rsp_t;

  // Control broadcast to every cell: open a gap, close a gap, and the
  // word that fills an opened gap.
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

@@ rtl/plc_cell.sv @@
// One entry cell of the positional list store. It holds one list word and
// shifts toward the tail on insert or toward the head on delete.
// Depends on plc_pkg.
module plc_cell #(
  parameter int unsigned POS_W = 7,
  parameter int unsigned SLOT  = 0
) (
  input  logic                               clk,
  input  plc_pkg::cell_ctl_t                 ctl,
  input  logic [POS_W-1:0]                   pos,
  input  logic signed [plc_pkg::VALUE_W-1:0] left,
  input  logic signed [plc_pkg::VALUE_W-1:0] right,
  output logic signed [plc_pkg::VALUE_W-1:0] data,
  output logic signed [plc_pkg::VALUE_W-1:0] rd
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(SLOT);

  logic                               at_pos;
  logic                               past_pos;
  logic signed [plc_pkg::VALUE_W-1:0] data_next;

  assign at_pos   = (pos == MY_POS);
  assign past_pos = (MY_POS > pos);

  // Insert takes the new word at the gap and the left neighbor behind it;
  // delete takes the right neighbor from the gap onward.
  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (at_pos) begin
        data_next = ctl.value;
      end else if (past_pos) begin
        data_next = left;
      end
    end else if (ctl.del) begin
      if (at_pos || past_pos) begin
        data_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Masked word for the read OR-reduction.
  assign rd = at_pos ? data : '0;

endmodule

@@ rtl/positional_list_store.sv @@
// Positional list store: an ordered list of up to CAPACITY signed 32-bit
// words kept packed at positions 0 to count-1.
// Request channel (req, req_valid, req_stall): one operation per beat --
// append, prepend, insert at index, read at index, delete head, delete
// tail, delete at index.
// Response channel (rsp, rsp_valid, rsp_stall): exactly one beat per
// request, carrying the read word (-1 for a bad read index, 0 when not a
// read), a status (ok, invalid index, empty, full) and the new count.
// Storage is a row of CAPACITY cells; an insert or delete shifts every cell
// behind the position by one place, and a read is an AND-OR select across
// the row.
// The response beat comes in the cycle after its request beat; one request
// is taken every cycle while responses drain. The response register is the
// only stage; when the receiver stalls it holds its beat and req_stall is
// raised until the beat is taken.
// Reset empties the list and drops any pending response. Cell contents are
// not reset; no operation reads beyond the count.
module positional_list_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  plc_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output plc_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > plc_pkg::INDEX_W) ? CNT_W : plc_pkg::INDEX_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [CMP_W-1:0]      idx_x;
  logic [CMP_W-1:0]      cnt_x;
  logic [CNT_W-1:0]      pos;
  plc_pkg::cell_ctl_t    ctl;
  plc_pkg::rsp_t         rsp_next;
  logic                  fire;
  logic signed [plc_pkg::VALUE_W-1:0] read_word;

  logic signed [plc_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  logic signed [plc_pkg::VALUE_W-1:0] cell_rd   [CAPACITY];

  assign req_stall = rsp_valid && rsp_stall;
  assign fire      = req_valid && !req_stall;
  assign idx_x     = CMP_W'(req.index);
  assign cnt_x     = CMP_W'(cnt);

  // Decode the operation into status, shift control and the new count.
  always_comb begin
    ctl.ins             = 1'b0;
    ctl.del             = 1'b0;
    ctl.value           = req.value;
    pos                 = '0;
    rsp_next.read_value = '0;
    rsp_next.status     = plc_pkg::ST_OK;
    case (req.func)
      plc_pkg::FN_APPEND: begin
        pos = cnt;
        if (cnt == CAP) begin
          rsp_next.status = plc_pkg::ST_FULL;
        end else begin
          ctl.ins = 1'b1;
        end
      end
      plc_pkg::FN_PREPEND: begin
        if (cnt == CAP) begin
          rsp_next.status = plc_pkg::ST_FULL;
        end else begin
          ctl.ins = 1'b1;
        end
      end
      plc_pkg::FN_INSERT: begin
        pos = idx_x[CNT_W-1:0];
        if (idx_x > cnt_x) begin
          rsp_next.status = plc_pkg::ST_INVALID;
        end else if (cnt == CAP) begin
          rsp_next.status = plc_pkg::ST_FULL;
        end else begin
          ctl.ins = 1'b1;
        end
      end
      plc_pkg::FN_READ: begin
        pos = idx_x[CNT_W-1:0];
        if (idx_x < cnt_x) begin
          rsp_next.read_value = read_word;
        end else begin
          rsp_next.read_value = plc_pkg::READ_BAD;
          rsp_next.status     = plc_pkg::ST_INVALID;
        end
      end
      plc_pkg::FN_DEL_HEAD: begin
        if (cnt == '0) begin
          rsp_next.status = plc_pkg::ST_EMPTY;
        end else begin
          ctl.del = 1'b1;
        end
      end
      plc_pkg::FN_DEL_TAIL: begin
        pos = cnt - CNT_W'(1);
        if (cnt == '0) begin
          rsp_next.status = plc_pkg::ST_EMPTY;
        end else begin
          ctl.del = 1'b1;
        end
      end
      plc_pkg::FN_DEL_AT: begin
        pos = idx_x[CNT_W-1:0];
        if (cnt == '0) begin
          rsp_next.status = plc_pkg::ST_EMPTY;
        end else if (idx_x >= cnt_x) begin
          rsp_next.status = plc_pkg::ST_INVALID;
        end else begin
          ctl.del = 1'b1;
        end
      end
      default: begin
        rsp_next.status = plc_pkg::ST_INVALID;
      end
    endcase

    // Cells only move on an accepted beat.
    if (!fire) begin
      ctl.ins = 1'b0;
      ctl.del = 1'b0;
    end

    cnt_next = cnt;
    if (req.func != plc_pkg::FN_READ && rsp_next.status == plc_pkg::ST_OK) begin
      if (ctl.ins) begin
        cnt_next = cnt + CNT_W'(1);
      end else if (ctl.del) begin
        cnt_next = cnt - CNT_W'(1);
      end
    end
    rsp_next.count = plc_pkg::COUNT_W'(cnt_next);
  end

  // The row of entry cells; the ends see zero from outside the row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [plc_pkg::VALUE_W-1:0] left_word;
    logic signed [plc_pkg::VALUE_W-1:0] right_word;

    if (i == 0) begin : g_head
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = cell_data[i+1];
    end

    plc_cell #(
      .POS_W (CNT_W),
      .SLOT  (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pos   (pos),
      .left  (left_word),
      .right (right_word),
      .data  (cell_data[i]),
      .rd    (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero word.
  always_comb begin
    read_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_word = read_word | cell_rd[i];
    end
  end

  // Count and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        cnt       <= cnt_next;
        rsp       <= rsp_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CAP)
    else $error("entry count above capacity");

  // A gap is never opened and closed at once.
  a_ins_del: assert property (@(posedge clk) disable iff (rst) !(ctl.ins && ctl.del))
    else $error("insert and delete in the same cycle");

  // An insert grows the list by exactly one.
  a_ins_cnt: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("insert did not grow the count by one");

  // Without an accepted request the count holds.
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(cnt))
    else $error("count changed without a request beat");

endmodule

@@ tb/positional_list_store_checker.sv @@
`timescale 1ns / 1ps
// Checker for the positional list store: watches both channels, keeps its own copy
// of the list and compares every response beat with the predicted one.
// Depends on plc_pkg for the beat types and the operation and status codes.
module positional_list_store_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  plc_pkg::req_t req,
  input  logic          req_valid,
  input  logic          req_stall,
  input  plc_pkg::rsp_t rsp,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  output int            fail_count,
  output int            outstanding,
  output int            fill_level,
  output int            beats_checked,
  output int            peak_fill,
  output int            full_refusals,
  output int            empty_refusals
);
  import plc_pkg::*;

  // Stop printing after this many mismatches; counting goes on.
  localparam int PRINT_CAP = 100;

  // Shadow copy of the list and the responses still owed by the block.
  logic signed [VALUE_W-1:0] list_words [CAPACITY];
  int unsigned               list_len;
  rsp_t                      owed_rsp [$];

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Applies one operation to the shadow list and returns the response it owes.
  function automatic rsp_t apply_list_op(input req_t item);
    rsp_t        result;
    int unsigned pos;
    int unsigned i;
    result.read_value = '0;
    result.status     = ST_OK;
    pos               = item.index;
    case (item.func)
      FN_APPEND, FN_PREPEND, FN_INSERT: begin
        if (item.func == FN_APPEND) begin
          pos = list_len;
        end else if (item.func == FN_PREPEND) begin
          pos = 0;
        end
        // A position past the tail is rejected before the full test.
        if (pos > list_len) begin
          result.status = ST_INVALID;
        end else if (list_len >= CAPACITY) begin
          result.status = ST_FULL;
        end else begin
          for (i = list_len; i > pos; i--) begin
            list_words[i] = list_words[i-1];
          end
          list_words[pos] = item.value;
          list_len++;
        end
      end
      FN_READ: begin
        if (pos < list_len) begin
          result.read_value = list_words[pos];
        end else begin
          result.read_value = READ_BAD;
          result.status     = ST_INVALID;
        end
      end
      FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_AT: begin
        if (item.func == FN_DEL_HEAD) begin
          pos = 0;
        end else if (item.func == FN_DEL_TAIL) begin
          pos = list_len - 1;
        end
        // An empty list is reported before any index check.
        if (list_len == 0) begin
          result.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          result.status = ST_INVALID;
        end else begin
          for (i = pos; i + 1 < list_len; i++) begin
            list_words[i] = list_words[i+1];
          end
          list_len--;
        end
      end
      default: begin
        result.status = ST_INVALID;
      end
    endcase
    result.count = list_len[COUNT_W-1:0];
    return result;
  endfunction

  // Retire response beats against the oldest prediction, then predict new requests.
  // A response never belongs to a request taken at the same edge.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      list_len = 0;
      owed_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        beats_checked++;
        if (owed_rsp.size() == 0) begin
          report_mismatch($sformatf("response beat with no request waiting (count %0d)",
                                    rsp.count));
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.read_value !== want.read_value) begin
            report_mismatch($sformatf("read_value got %0d, want %0d",
                                      rsp.read_value, want.read_value));
          end
          if (rsp.status !== want.status) begin
            report_mismatch($sformatf("status got %0d, want %0d", rsp.status, want.status));
          end
          if (rsp.count !== want.count) begin
            report_mismatch($sformatf("count got %0d, want %0d", rsp.count, want.count));
          end
        end
      end
      if (req_valid && !req_stall) begin
        want = apply_list_op(req);
        owed_rsp.push_back(want);
        if (want.status == ST_FULL) begin
          full_refusals++;
        end
        if (want.status == ST_EMPTY) begin
          empty_refusals++;
        end
        if (int'(list_len) > peak_fill) begin
          peak_fill = list_len;
        end
      end
    end
    // Published with nonblocking updates so the stimulus side reads them without a race.
    outstanding <= owed_rsp.size();
    fill_level  <= list_len;
  end

endmodule

@@ tb/positional_list_store_tb.sv @@
`timescale 1ns / 1ps
// Top of the positional list store testbench: clock, reset, request and response
// traffic and the verdict. Depends on plc_pkg, the block and the list checker.
module positional_list_store_tb;
  import plc_pkg::*;

  localparam int unsigned CAPACITY        = 64;
  localparam int          HOLD_OFF_CYCLES = 150;
  localparam int          IDLE_LIMIT      = 1000;
  localparam int          DRAIN_CYCLES    = 8;

  // The one function code with no operation behind it.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  logic clk;
  logic rst          = 1'b1;
  req_t req          = '0;
  logic req_valid    = 1'b0;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall    = 1'b0;

  // Traffic controls shared between the stimulus and the response side.
  logic req_idling   = 1'b1;
  logic rsp_idling   = 1'b1;
  logic hold_off_req = 1'b0;

  int fail_count;
  int outstanding;
  int fill_level;
  int beats_checked;
  int peak_fill;
  int full_refusals;
  int empty_refusals;
  int items_sent     = 0;
  int directed_items = 0;
  int idle_cycles    = 0;

  positional_list_store #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp      (rsp),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall)
  );

  positional_list_store_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .rsp           (rsp),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .fill_level    (fill_level),
    .beats_checked (beats_checked),
    .peak_fill     (peak_fill),
    .full_refusals (full_refusals),
    .empty_refusals(empty_refusals)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length in cycles: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_req(input logic [FUNC_W-1:0] func,
                                    input logic [INDEX_W-1:0] index,
                                    input logic signed [VALUE_W-1:0] value);
    req_t item;
    item.func  = func;
    item.index = index;
    item.value = value;
    return item;
  endfunction

  // Random operation steered by the current fill: grow_pct sets the share of
  // inserts, and most indexes land in or just past the live range.
  function automatic req_t random_op(input int fill, input int unsigned grow_pct);
    req_t        item;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      item.func = FN_UNUSED;
    end else if (roll < 2 + grow_pct) begin
      case ($urandom_range(0, 2))
        0:       item.func = FN_APPEND;
        1:       item.func = FN_PREPEND;
        default: item.func = FN_INSERT;
      endcase
    end else if (roll < 17 + grow_pct) begin
      item.func = FN_READ;
    end else begin
      case ($urandom_range(0, 2))
        0:       item.func = FN_DEL_HEAD;
        1:       item.func = FN_DEL_TAIL;
        default: item.func = FN_DEL_AT;
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      item.index = INDEX_W'($urandom_range(0, 127));
    end else begin
      item.index = INDEX_W'($urandom_range(0, fill));
    end
    case ($urandom_range(0, 9))
      0:       item.value = 32'sh8000_0000;
      1:       item.value = 32'sh7fff_ffff;
      2:       item.value = '0;
      3:       item.value = -32'sd1;
      default: item.value = $urandom;
    endcase
    return item;
  endfunction

  // Offers one request beat and returns at the edge where it is taken.
  task automatic send_beat(input req_t item);
    int gap;
    gap = req_idling ? pick_gap() : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic run_phase(input int count, input int unsigned grow_pct);
    repeat (count) send_beat(random_op(fill_level, grow_pct));
  endtask

  // Response side: random stall runs, free stretches, and one long hold-off on request.
  initial begin : rsp_side
    bit hold_off_done;
    hold_off_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        rsp_stall    <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Watchdog: any cycle that moves a beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("no beat moved for %0d cycles", IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: every operation on an empty list, the value extremes,
    // bad indexes, the unused code, and emptying through each kind of delete.
    send_beat(make_req(FN_READ,     7'd0,   32'sd0));
    send_beat(make_req(FN_DEL_HEAD, 7'd0,   32'sd0));
    send_beat(make_req(FN_DEL_TAIL, 7'd0,   32'sd0));
    send_beat(make_req(FN_DEL_AT,   7'd0,   32'sd0));
    send_beat(make_req(FN_INSERT,   7'd1,   32'sd11));
    send_beat(make_req(FN_APPEND,   7'd0,   32'sh7fff_ffff));
    send_beat(make_req(FN_PREPEND,  7'd127, 32'sh8000_0000));
    send_beat(make_req(FN_INSERT,   7'd1,   -32'sd1));
    send_beat(make_req(FN_INSERT,   7'd3,   32'sd0));
    send_beat(make_req(FN_INSERT,   7'd127, 32'sd5));
    send_beat(make_req(FN_READ,     7'd0,   32'sd0));
    send_beat(make_req(FN_READ,     7'd3,   32'sd0));
    send_beat(make_req(FN_READ,     7'd4,   32'sd0));
    send_beat(make_req(FN_READ,     7'd127, -32'sd1));
    send_beat(make_req(FN_DEL_AT,   7'd4,   32'sd0));
    send_beat(make_req(FN_DEL_AT,   7'd1,   32'sd0));
    send_beat(make_req(FN_DEL_TAIL, 7'd0,   32'sd0));
    send_beat(make_req(FN_DEL_HEAD, 7'd0,   32'sd0));
    send_beat(make_req(FN_UNUSED,   7'd127, -32'sd1));
    send_beat(make_req(FN_DEL_AT,   7'd0,   32'sd0));
    send_beat(make_req(FN_READ,     7'd0,   32'sd0));
    send_beat(make_req(FN_APPEND,   7'd0,   32'sd42));
    send_beat(make_req(FN_DEL_TAIL, 7'd0,   32'sd0));
    send_beat(make_req(FN_PREPEND,  7'd0,   -32'sd42));
    send_beat(make_req(FN_DEL_HEAD, 7'd0,   32'sd0));
    directed_items = items_sent;

    // Random part: fill past full, drain past empty, then mixed traffic.
    run_phase(110, 75);
    run_phase(110, 8);

    // A stretch with no idling on either side.
    req_idling = 1'b0;
    rsp_idling <= 1'b0;
    run_phase(40, 40);

    // The receiver holds off while requests keep coming, so the block backs up.
    hold_off_req <= 1'b1;
    run_phase(30, 40);

    req_idling = 1'b1;
    rsp_idling <= 1'b1;
    run_phase(100, 75);
    run_phase(90, 8);

    // Wind down: stop offering, stop stalling, and let the last responses land.
    req_valid  <= 1'b0;
    rsp_idling <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request beats (%0d directed) and checked %0d response beats.",
             items_sent, directed_items, beats_checked);
    $display("List reached %0d of %0d entries; %0d inserts hit a full list, %0d %s",
             peak_fill, CAPACITY, full_refusals, empty_refusals,
             "deletes an empty one.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
